>>> rtl/delta_gamma_pattern_matcher_unit_assert.svh
// assertion macros for the delta-gamma pattern matcher
// expects aclk and aresetn in the scope where a macro is used
`ifndef DELTA_GAMMA_PATTERN_MATCHER_UNIT_ASSERT_SVH
`define DELTA_GAMMA_PATTERN_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DGPM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dgpm assertion failed");

// next-cycle implication, checked outside reset
`define DGPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dgpm assertion failed");

`endif

>>> rtl/dgpm_pkg.sv
// shared types and constants for the delta-gamma pattern matcher
// no dependencies
package dgpm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int SYMBOL_BITS = 8;
    localparam int IDX_BITS    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam int REQ_BITS    = 2;
    localparam int PIDX_BITS   = 5;
    localparam int LEN_BITS    = 6;
    localparam int DELTA_BITS  = 8;
    localparam int SUM_BITS    = 13;
    localparam int POS_BITS    = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;

    // request codes
    localparam logic [REQ_BITS-1:0] REQ_PATTERN = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_TEXT    = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_START   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELTA_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAMMA_LIMIT    = 2'd2;

    localparam logic [LEN_BITS-1:0]   RESET_PATTERN_LENGTH = 6'd1;
    localparam logic [DELTA_BITS-1:0] RESET_DELTA_LIMIT    = 8'd0;
    localparam logic [SUM_BITS-1:0]   RESET_GAMMA_LIMIT    = 13'd8160;

    typedef struct packed {
        logic [REQ_BITS-1:0]  req_type;
        logic [PIDX_BITS-1:0] pattern_index;
        logic [7:0]           symbol_value;
    } dgpm_in_t;

    typedef struct packed {
        logic [POS_BITS-1:0] start_position;
        logic [SUM_BITS-1:0] total_difference;
    } dgpm_out_t;

    // match bit and running sum of one pattern position
    typedef struct packed {
        logic                match;
        logic [SUM_BITS-1:0] sum;
    } tap_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic write;
    } cell_ctl_t;

    typedef struct packed {
        logic                shift;
        logic                clear;
        logic                write;
        logic [IDX_BITS-1:0] wr_idx;
    } chain_ctl_t;

endpackage

>>> rtl/dgpm_cell.sv
// one pattern position: stored symbol, match bit and running difference sum
// depends on dgpm_pkg
module dgpm_cell
    import dgpm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cell_ctl_t              ctl,
    input  logic [SYMBOL_BITS-1:0] sym,
    input  logic [DELTA_BITS-1:0]  delta,
    input  tap_t                   prev,
    output tap_t                   cur
);

    logic [SYMBOL_BITS-1:0] pattern_reg;
    logic                   match_reg, match_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SYMBOL_BITS-1:0] diff;
    logic                   ok;

    always_comb begin
        diff = (sym >= pattern_reg) ? (sym - pattern_reg) : (pattern_reg - sym);
        ok   = (32'(diff) <= 32'(delta));
        match_next = match_reg;
        sum_next   = sum_reg;
        if (ctl.clear) begin
            match_next = 1'b0;
            sum_next   = '0;
        end else if (ctl.shift) begin
            match_next = prev.match & ok;
            sum_next   = prev.sum + (ok ? SUM_BITS'(diff) : '0);
        end
    end

    // pattern symbol is undefined until written
    always_ff @(posedge aclk) begin
        if (ctl.write) begin
            pattern_reg <= sym;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
            sum_reg   <= '0;
        end else begin
            match_reg <= match_next;
            sum_reg   <= sum_next;
        end
    end

    assign cur.match = match_reg;
    assign cur.sum   = sum_reg;

endmodule

>>> rtl/dgpm_cell_chain.sv
// row of matcher cells, each fed by its left neighbor, with a tap at a selectable position
// depends on dgpm_pkg and dgpm_cell
module dgpm_cell_chain
    import dgpm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  chain_ctl_t             ctl,
    input  logic [SYMBOL_BITS-1:0] sym,
    input  logic [DELTA_BITS-1:0]  delta,
    input  logic [IDX_BITS-1:0]    tap_idx,
    output tap_t                   tap
);

    tap_t cell_out [MAX_PATTERN];

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        cell_ctl_t cctl;
        tap_t      prev;

        assign cctl.shift = ctl.shift;
        assign cctl.clear = ctl.clear;
        assign cctl.write = ctl.write && (ctl.wr_idx == IDX_BITS'(j));

        // position zero always starts a fresh window
        if (j == 0) begin : g_head
            assign prev.match = 1'b1;
            assign prev.sum   = '0;
        end else begin : g_body
            assign prev = cell_out[j-1];
        end

        dgpm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (cctl),
            .sym     (sym),
            .delta   (delta),
            .prev    (prev),
            .cur     (cell_out[j])
        );
    end

    assign tap = cell_out[tap_idx];

endmodule

>>> rtl/delta_gamma_pattern_matcher_unit.sv
// delta-gamma pattern matcher, top level
// depends on dgpm_pkg, dgpm_cell_chain and the assertion macro header
//
// usage
//   s_ channel: one request per transfer. pattern writes load one pattern
//   symbol, text requests stream one text symbol, start requests clear the
//   search state and text counter (the pattern is kept).
//   m_ channel: one transfer per matching window, carrying the window's start
//   position and its total difference.
//   cfg_ channel: register writes (pattern length, delta, gamma); always
//   ready, to be used only while the block is idle.
// timing
//   one request per cycle while s_ready is high. a text symbol updates every
//   cell of the chain at the edge it is taken; in the cycle after, the tap at
//   the last pattern position is checked and a hit is loaded into the output
//   register, which raises m_valid, unless an untaken earlier result holds it.
//   s_ready drops only while a hit is waiting and the output register holds
//   an earlier result that the receiver has not taken.
// reset
//   aresetn is synchronous, active low: clears match bits, sums, the text
//   counter, the pipeline and the registers to their defaults.
`include "delta_gamma_pattern_matcher_unit_assert.svh"

module delta_gamma_pattern_matcher_unit
    import dgpm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  dgpm_in_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output dgpm_out_t                m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    // configuration registers
    logic [LEN_BITS-1:0]   pattern_length_reg;
    logic [DELTA_BITS-1:0] delta_limit_reg;
    logic [SUM_BITS-1:0]   gamma_limit_reg;

    // search counter and check stage
    logic [POS_BITS-1:0] text_counter_reg, text_counter_next;
    logic                eval_vld_reg, eval_vld_next;
    logic [POS_BITS-1:0] eval_start_reg;

    // output register
    logic      m_valid_reg, m_valid_next;
    dgpm_out_t m_data_reg;

    logic                accept;
    logic                is_text;
    logic                hit;
    logic                eval_stall;
    logic                out_load;
    logic [LEN_BITS-1:0] m_act;
    logic [IDX_BITS-1:0] last_idx;
    logic [POS_BITS-1:0] start_pos;
    chain_ctl_t          chain_ctl;
    tap_t                tap;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= RESET_PATTERN_LENGTH;
            delta_limit_reg    <= RESET_DELTA_LIMIT;
            gamma_limit_reg    <= RESET_GAMMA_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_BITS-1:0];
                CFG_DELTA_LIMIT:    delta_limit_reg    <= cfg_data[DELTA_BITS-1:0];
                CFG_GAMMA_LIMIT:    gamma_limit_reg    <= cfg_data[SUM_BITS-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // active pattern length: zero acts as one, long values clamp to the chain size
    always_comb begin
        if (pattern_length_reg == '0) begin
            m_act = LEN_BITS'(1);
        end else if (32'(pattern_length_reg) > MAX_PATTERN) begin
            m_act = LEN_BITS'(MAX_PATTERN);
        end else begin
            m_act = pattern_length_reg;
        end
    end

    assign last_idx  = IDX_BITS'(m_act - LEN_BITS'(1));
    // window start for the symbol now being taken, wraps modulo 2^32
    assign start_pos = text_counter_reg - POS_BITS'(m_act) + POS_BITS'(1);

    // hit check on the chain state left by the previous text symbol
    assign hit        = tap.match && (tap.sum <= gamma_limit_reg);
    assign eval_stall = eval_vld_reg && hit && m_valid_reg && !m_ready;
    assign out_load   = eval_vld_reg && hit && !eval_stall;

    assign s_ready = !eval_stall;
    assign accept  = s_valid && s_ready;
    assign is_text = (s_data.req_type == REQ_TEXT);

    always_comb begin
        chain_ctl.shift  = accept && is_text;
        chain_ctl.clear  = accept && (s_data.req_type == REQ_START);
        // writes past the chain are dropped
        chain_ctl.write  = accept && (s_data.req_type == REQ_PATTERN)
                           && (32'(s_data.pattern_index) < MAX_PATTERN);
        chain_ctl.wr_idx = IDX_BITS'(s_data.pattern_index);
    end

    dgpm_cell_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (chain_ctl),
        .sym     (SYMBOL_BITS'(s_data.symbol_value)),
        .delta   (delta_limit_reg),
        .tap_idx (last_idx),
        .tap     (tap)
    );

    always_comb begin
        text_counter_next = text_counter_reg;
        if (chain_ctl.clear) begin
            text_counter_next = '0;
        end else if (chain_ctl.shift) begin
            text_counter_next = text_counter_reg + POS_BITS'(1);
        end
    end

    // check stage holds while a hit waits for the output register
    always_comb begin
        eval_vld_next = eval_vld_reg;
        if (!eval_stall) begin
            eval_vld_next = chain_ctl.shift;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_counter_reg <= '0;
            eval_vld_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            text_counter_reg <= text_counter_next;
            eval_vld_reg     <= eval_vld_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (chain_ctl.shift) begin
            eval_start_reg <= start_pos;
        end
        if (out_load) begin
            m_data_reg.start_position   <= eval_start_reg;
            m_data_reg.total_difference <= tap.sum;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // input back-pressure only comes from a full, stalled output register
    `DGPM_ASSERT_IMPL(a_ready_only_on_stall, !s_ready, m_valid && !m_ready)
    // every text transfer reaches the check stage
    `DGPM_ASSERT_NEXT(a_text_to_check, s_valid && s_ready && is_text, eval_vld_reg)
    // a start transfer restarts the text index
    `DGPM_ASSERT_NEXT(a_start_clears_counter, s_valid && s_ready &&
                      (s_data.req_type == REQ_START), text_counter_reg == '0)
    // a hit that finds a result still waiting stays in the check stage
    `DGPM_ASSERT_NEXT(a_stall_holds_check, eval_stall, eval_vld_reg)

endmodule

>>> tb/tb_delta_gamma_pattern_matcher_unit.sv
// self-checking testbench for delta_gamma_pattern_matcher_unit: a window-match predictor
// follows every request transfer and checks each result transfer in order
// depends on dgpm_pkg and the delta_gamma_pattern_matcher_unit rtl
`timescale 1ns / 100ps

module tb_delta_gamma_pattern_matcher_unit;
    import dgpm_pkg::*;

    // request code the block must ignore
    localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
    // register index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    // cycles after the last result before the block counts as drained
    localparam int DRAIN_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    dgpm_in_t                 s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    dgpm_out_t                m_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    delta_gamma_pattern_matcher_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // requests waiting to be sent, and matches the predictor expects back
    dgpm_in_t  request_queue[$];
    dgpm_out_t expected_matches[$];

    // predictor state: pattern, per-position match bit and running sum, text index
    logic [SYMBOL_BITS-1:0] pat_mem[MAX_PATTERN];
    logic                   win_ok[MAX_PATTERN];
    logic [SUM_BITS-1:0]    win_sum[MAX_PATTERN];
    logic [POS_BITS-1:0]    text_pos;
    logic [LEN_BITS-1:0]    cfg_len   = RESET_PATTERN_LENGTH;
    logic [DELTA_BITS-1:0]  cfg_delta = RESET_DELTA_LIMIT;
    logic [SUM_BITS-1:0]    cfg_gamma = RESET_GAMMA_LIMIT;

    // pattern as the stimulus generator sees it, ahead of the predictor
    logic [SYMBOL_BITS-1:0] plan_pattern[MAX_PATTERN];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // pattern length in use: zero acts as one, above the store size is clamped
    function automatic int clamp_len(input logic [LEN_BITS-1:0] len);
        if (len == 0) return 1;
        if (len > MAX_PATTERN) return MAX_PATTERN;
        return int'(len);
    endfunction

    // mostly no pause, often a short one, now and then a long one
    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // advance the window state by one accepted request, queue the match if any
    task automatic predict_matches(input dgpm_in_t req);
        logic [SYMBOL_BITS-1:0] diff;
        logic                   ok;
        logic                   prev_ok;
        logic [SUM_BITS-1:0]    prev_sum;
        int                     m;
        dgpm_out_t              hit;
        case (req.req_type)
            REQ_PATTERN: begin
                pat_mem[req.pattern_index] = req.symbol_value;
            end
            REQ_START: begin
                // new text: search state cleared, pattern kept
                for (int j = 0; j < MAX_PATTERN; j++) begin
                    win_ok[j]  = 1'b0;
                    win_sum[j] = '0;
                end
                text_pos = '0;
            end
            REQ_TEXT: begin
                // highest position first so each reads the older neighbor
                for (int j = MAX_PATTERN - 1; j >= 0; j--) begin
                    diff = (req.symbol_value >= pat_mem[j]) ?
                           req.symbol_value - pat_mem[j] : pat_mem[j] - req.symbol_value;
                    ok       = (diff <= cfg_delta);
                    prev_ok  = (j == 0) ? 1'b1 : win_ok[j-1];
                    prev_sum = (j == 0) ? '0 : win_sum[j-1];
                    win_ok[j]  = prev_ok && ok;
                    // an over-delta symbol adds nothing, its match bit already drops
                    win_sum[j] = prev_sum + (ok ? SUM_BITS'(diff) : '0);
                end
                m = clamp_len(cfg_len);
                hit.start_position   = text_pos - POS_BITS'(m) + POS_BITS'(1);
                hit.total_difference = win_sum[m-1];
                text_pos = text_pos + POS_BITS'(1);
                if (win_ok[m-1] && win_sum[m-1] <= cfg_gamma)
                    expected_matches = {expected_matches, hit};
            end
            default: ;  // unknown request: no effect
        endcase
    endtask

    // request driver: one item per transfer, random gaps between items
    int unsigned send_pause = 0;
    int unsigned send_calm  = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            send_pause <= 0;
            send_calm  <= 0;
        end else begin
            if (s_valid && s_ready)
                predict_matches(s_data);
            // the slot is free when nothing is offered or the offer just went through
            if (!s_valid || s_ready) begin
                if (send_pause != 0) begin
                    send_pause <= send_pause - 1;
                    s_valid    <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= request_queue.pop_front();
                    // calm stretches send back to back
                    if (send_calm != 0) begin
                        send_calm <= send_calm - 1;
                    end else begin
                        send_pause <= pick_pause();
                        if ($urandom_range(0, 15) == 0)
                            send_calm <= $urandom_range(20, 80);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each result transfer with the oldest expected match
    int unsigned recv_pause = 0;
    int unsigned recv_calm  = 0;

    always @(posedge aclk) begin : result_check
        dgpm_out_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_pause <= 0;
            recv_calm  <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_matches.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: start %0d diff %0d",
                                 m_data.start_position, m_data.total_difference);
                end else begin
                    want = expected_matches.pop_front();
                    if (m_data.start_position !== want.start_position ||
                        m_data.total_difference !== want.total_difference) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("want start %0d diff %0d, got start %0d diff %0d",
                                     want.start_position, want.total_difference,
                                     m_data.start_position, m_data.total_difference);
                    end
                end
            end
            // receiver back-pressure with the same mix of gaps
            if (recv_pause != 0) begin
                recv_pause <= recv_pause - 1;
                m_ready    <= 1'b0;
            end else if (recv_calm != 0) begin
                recv_calm <= recv_calm - 1;
                m_ready   <= 1'b1;
            end else begin
                m_ready    <= 1'b1;
                recv_pause <= pick_pause();
                if ($urandom_range(0, 15) == 0)
                    recv_calm <= $urandom_range(20, 80);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_delta_gamma_pattern_matcher_unit: done, errors");
            $finish;
        end
    end

    task automatic queue_item(input logic [REQ_BITS-1:0] req,
                              input logic [PIDX_BITS-1:0] idx,
                              input logic [SYMBOL_BITS-1:0] sym);
        dgpm_in_t item;
        item.req_type      = req;
        item.pattern_index = idx;
        item.symbol_value  = sym;
        if (req == REQ_PATTERN)
            plan_pattern[idx] = sym;
        request_queue = {request_queue, item};
    endtask

    task automatic queue_text(input logic [SYMBOL_BITS-1:0] sym);
        queue_item(REQ_TEXT, 5'($urandom), sym);
    endtask

    // text run that follows the pattern, each symbol within delta of it
    task automatic queue_window(input int len, input int delta, input bit exact);
        int off;
        int v;
        for (int j = 0; j < len; j++) begin
            off = exact ? 0 : int'($urandom_range(0, 2 * delta)) - delta;
            v   = int'(plan_pattern[j]) + off;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            queue_text(SYMBOL_BITS'(v));
        end
    endtask

    // hold the sender until every transfer is through and every match has come back
    task automatic wait_idle();
        do @(posedge aclk);
        while (request_queue.size() != 0 || s_valid || expected_matches.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_PATTERN_LENGTH: cfg_len   = val[LEN_BITS-1:0];
            CFG_DELTA_LIMIT:    cfg_delta = val[DELTA_BITS-1:0];
            CFG_GAMMA_LIMIT:    cfg_gamma = val;
            default: ;  // unused index
        endcase
        cfg_valid <= 1'b0;
    endtask

    // one configuration, then a mix mostly made of near-pattern windows
    task automatic run_phase(input logic [CFG_DATA_BITS-1:0] len,
                             input logic [CFG_DATA_BITS-1:0] delta,
                             input logic [CFG_DATA_BITS-1:0] gamma,
                             input int n);
        int m;
        int d;
        int k;
        int count;
        int unsigned pick;
        wait_idle();
        write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom));
        write_reg(CFG_PATTERN_LENGTH, len);
        write_reg(CFG_DELTA_LIMIT, delta);
        write_reg(CFG_GAMMA_LIMIT, gamma);
        m = clamp_len(len[LEN_BITS-1:0]);
        d = int'(delta[DELTA_BITS-1:0]);
        queue_item(REQ_START, 5'($urandom), 8'($urandom));
        count = 0;
        while (count < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                queue_window(m, d, $urandom_range(0, 2) == 0);
                count += m;
            end else if (pick < 65) begin
                // window cut short by a random symbol
                k = $urandom_range(1, m);
                queue_window(k, d, 1'b0);
                queue_text(8'($urandom));
                count += k + 1;
            end else if (pick < 78) begin
                queue_text(8'($urandom));
                count++;
            end else if (pick < 84) begin
                queue_item(REQ_START, 5'($urandom), 8'($urandom));
                count++;
            end else if (pick < 92) begin
                // pattern changes in mid-text keep the search state
                queue_item(REQ_PATTERN, 5'($urandom), 8'($urandom));
                count++;
            end else begin
                queue_item(REQ_UNUSED, 5'($urandom), 8'($urandom));
                count++;
            end
        end
    endtask

    initial begin
        // predictor search state starts out as after reset
        for (int j = 0; j < MAX_PATTERN; j++) begin
            win_ok[j]  = 1'b0;
            win_sum[j] = '0;
        end
        text_pos = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // load every pattern entry so no unwritten entry is ever read
        for (int j = 0; j < MAX_PATTERN; j++)
            queue_item(REQ_PATTERN, PIDX_BITS'(j), (j == 0) ? 8'd0 : 8'($urandom));

        // reset settings: one symbol, exact match only
        queue_text(8'd0);
        queue_text(8'd255);
        queue_text(8'd1);
        queue_item(REQ_UNUSED, 5'd31, 8'd255);
        queue_text(8'd0);
        queue_item(REQ_START, 5'd0, 8'd0);
        queue_text(8'd0);
        queue_item(REQ_PATTERN, 5'd0, 8'd255);
        queue_text(8'd255);
        queue_text(8'd254);
        queue_item(REQ_PATTERN, 5'd31, 8'hA5);

        // widest delta, gamma one under the full difference
        wait_idle();
        write_reg(CFG_DELTA_LIMIT, 13'd255);
        write_reg(CFG_GAMMA_LIMIT, 13'd254);
        queue_text(8'd0);
        queue_text(8'd1);
        queue_text(8'd255);

        // length zero acts as one, gamma zero
        run_phase(13'd0, 13'd3, 13'd0, 40);
        // full length, anything goes
        run_phase(13'd32, 13'd255, 13'd8160, 60);
        // length above the store is clamped
        run_phase(13'd63, 13'd10, 13'd100, 70);
        // junk above the register widths is dropped
        run_phase(13'h1FC5, 13'h1F00, 13'd0, 50);
        run_phase(13'd33, 13'd20, 13'd8191, 50);
        for (int p = 0; p < 3; p++)
            run_phase(13'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 32 : 8)),
                      13'($urandom_range(0, 40)), 13'($urandom_range(0, 300)), 30);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("tb_delta_gamma_pattern_matcher_unit: done, clean");
        end else begin
            $display("tb_delta_gamma_pattern_matcher_unit: done, errors");
        end
        $finish;
    end

endmodule
